[rtl/bxavg_pkg.sv]
`default_nettype none

package bxavg_pkg;

  // output image limit and source size limit
  localparam int MAX_OUT_DIM = 32;
  localparam int MAX_SRC_DIM = 1024;

  localparam int OUT_W  = $clog2(MAX_OUT_DIM);          // output coordinate bits
  localparam int DIM_W  = 11;                           // register width
  localparam int POS_W  = 10;                           // source position bits
  localparam int BAND_W = OUT_W + 1;                    // band size, up to 32
  localparam int ACC_W  = DIM_W + OUT_W;                // band index times step
  localparam int SUM_W  = 18;                           // channel sum bits
  localparam int CNT_W  = 11;                           // pixels per band rectangle
  localparam int CH_N   = 4;                            // red, green, blue, alpha
  localparam int PIX_W  = 8;
  localparam int QBIT_W = $clog2(PIX_W);

  // configuration register indexes
  typedef enum logic {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [SUM_W-1:0] sum_t;

  // one finished band rectangle waiting for its division
  typedef struct packed {
    logic [OUT_W-1:0]       x;
    logic [OUT_W-1:0]       y;
    sum_t [CH_N-1:0]        sums;
    logic [CNT_W-1:0]       cnt;
    logic                   done;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_e;

  // clamp a register value to 1..MAX_SRC_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_SRC_DIM)) begin
      r = DIM_W'(MAX_SRC_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // band start i is (i * step) >> OUT_W: step is the size, or MAX_OUT_DIM for small sizes
  function automatic logic [DIM_W-1:0] band_step(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] r;
    if (dim < DIM_W'(MAX_OUT_DIM)) begin
      r = DIM_W'(MAX_OUT_DIM);
    end else begin
      r = dim;
    end
    return r;
  endfunction

  // output size along one axis
  function automatic logic [BAND_W-1:0] out_dim(input logic [DIM_W-1:0] dim);
    logic [BAND_W-1:0] r;
    if (dim < DIM_W'(MAX_OUT_DIM)) begin
      r = dim[BAND_W-1:0];
    end else begin
      r = BAND_W'(MAX_OUT_DIM);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/bxavg_pix_if.sv]
`default_nettype none

interface bxavg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  input in_alpha, output ready);
endinterface

`default_nettype wire

[rtl/bxavg_res_if.sv]
`default_nettype none

interface bxavg_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_x;
  logic [4:0] out_y;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       image_done;

  modport source (output valid, output out_x, output out_y, output out_red,
                  output out_green, output out_blue, output out_alpha,
                  output image_done, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_red,
                  input out_green, input out_blue, input out_alpha,
                  input image_done, output ready);
endinterface

`default_nettype wire

[rtl/bxavg_front.sv]
`default_nettype none

module bxavg_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [bxavg_pkg::DIM_W-1:0] cfg_data_i,
  bxavg_pix_if.sink                     pix_in,
  output logic                          push_o,
  output bxavg_pkg::job_t               job_o,
  input  wire logic                     full_i
);
  import bxavg_pkg::*;

  // effective source size
  logic [DIM_W-1:0] w_q, h_q, w_new, h_new;

  // position and band tracking
  logic [POS_W-1:0] src_col_q, src_row_q;
  logic [OUT_W-1:0] band_col_q, band_row_q;
  logic [DIM_W-1:0] col_start_q, row_start_q;
  logic [ACC_W-1:0] col_acc_q, row_acc_q;

  // per-column accumulators
  sum_t sums_q [CH_N][MAX_OUT_DIM];

  logic [DIM_W-1:0]  cstep, rstep, col_end, row_end;
  logic [DIM_W-1:0]  col_nxt, row_nxt;
  logic              last_col, last_row, col_wrap, row_wrap;
  logic              accept, emit;
  logic [PIX_W-1:0]  pix [CH_N];
  sum_t              sum_cur [CH_N];
  logic [DIM_W-1:0]  cw_full, rh_full;
  logic [2*BAND_W-1:0] cnt_full;
  logic [BAND_W-1:0] ow, oh;

  assign pix[0] = pix_in.in_red;
  assign pix[1] = pix_in.in_green;
  assign pix[2] = pix_in.in_blue;
  assign pix[3] = pix_in.in_alpha;

  // accept while the queue has room
  assign pix_in.ready = !full_i;
  assign accept       = pix_in.valid && pix_in.ready;

  // band geometry
  assign cstep   = band_step(w_q);
  assign rstep   = band_step(h_q);
  assign col_end = col_acc_q[ACC_W-1:OUT_W];
  assign row_end = row_acc_q[ACC_W-1:OUT_W];
  assign col_nxt = {1'b0, src_col_q} + DIM_W'(1);
  assign row_nxt = {1'b0, src_row_q} + DIM_W'(1);

  assign last_col = col_nxt >= col_end;
  assign last_row = row_nxt >= row_end;
  assign col_wrap = col_nxt >= w_q;
  assign row_wrap = row_nxt >= h_q;
  assign emit     = accept && last_col && last_row;

  // running sums including this beat
  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      sum_cur[c] = sums_q[c][band_col_q] + SUM_W'(pix[c]);
    end
  end

  // pixel count of the band rectangle
  assign cw_full  = col_end - col_start_q;
  assign rh_full  = row_end - row_start_q;
  assign cnt_full = cw_full[BAND_W-1:0] * rh_full[BAND_W-1:0];
  assign ow       = out_dim(w_q);
  assign oh       = out_dim(h_q);

  // job for the back end
  always_comb begin
    job_o.x    = band_col_q;
    job_o.y    = band_row_q;
    for (int c = 0; c < CH_N; c++) begin
      job_o.sums[c] = sum_cur[c];
    end
    job_o.cnt  = cnt_full[CNT_W-1:0];
    job_o.done = ({1'b0, band_col_q} + BAND_W'(1) == ow) &&
                 ({1'b0, band_row_q} + BAND_W'(1) == oh);
  end
  assign push_o = emit;

  // size that a configuration write leaves
  always_comb begin
    w_new = w_q;
    h_new = h_q;
    if (cfg_idx_i == REG_SRC_WIDTH) begin
      w_new = eff_dim(cfg_data_i);
    end else begin
      h_new = eff_dim(cfg_data_i);
    end
  end

  // size registers, counters and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= DIM_W'(MAX_OUT_DIM);
      h_q         <= DIM_W'(MAX_OUT_DIM);
      src_col_q   <= '0;
      src_row_q   <= '0;
      band_col_q  <= '0;
      band_row_q  <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      col_acc_q   <= ACC_W'(MAX_OUT_DIM);
      row_acc_q   <= ACC_W'(MAX_OUT_DIM);
      for (int c = 0; c < CH_N; c++) begin
        for (int i = 0; i < MAX_OUT_DIM; i++) begin
          sums_q[c][i] <= '0;
        end
      end
    end else if (cfg_we_i) begin
      // any write restarts the image
      w_q         <= w_new;
      h_q         <= h_new;
      src_col_q   <= '0;
      src_row_q   <= '0;
      band_col_q  <= '0;
      band_row_q  <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      col_acc_q   <= ACC_W'(band_step(w_new));
      row_acc_q   <= ACC_W'(band_step(h_new));
      for (int c = 0; c < CH_N; c++) begin
        for (int i = 0; i < MAX_OUT_DIM; i++) begin
          sums_q[c][i] <= '0;
        end
      end
    end else if (accept) begin
      for (int c = 0; c < CH_N; c++) begin
        sums_q[c][band_col_q] <= emit ? '0 : sum_cur[c];
      end
      if (col_wrap) begin
        src_col_q   <= '0;
        band_col_q  <= '0;
        col_start_q <= '0;
        col_acc_q   <= ACC_W'(cstep);
        if (row_wrap) begin
          src_row_q   <= '0;
          band_row_q  <= '0;
          row_start_q <= '0;
          row_acc_q   <= ACC_W'(rstep);
        end else begin
          src_row_q <= row_nxt[POS_W-1:0];
          if (last_row) begin
            band_row_q  <= band_row_q + OUT_W'(1);
            row_start_q <= row_end;
            row_acc_q   <= row_acc_q + ACC_W'(rstep);
          end
        end
      end else begin
        src_col_q <= col_nxt[POS_W-1:0];
        if (last_col) begin
          band_col_q  <= band_col_q + OUT_W'(1);
          col_start_q <= col_end;
          col_acc_q   <= col_acc_q + ACC_W'(cstep);
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bxavg_fifo.sv]
`default_nettype none

module bxavg_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  bxavg_pkg::job_t  data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output bxavg_pkg::job_t  data_o,
  output logic             empty_o
);
  import bxavg_pkg::*;

  // two-entry job queue
  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/bxavg_back.sv]
`default_nettype none

module bxavg_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  bxavg_pkg::job_t  job_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  bxavg_res_if.source      res_out
);
  import bxavg_pkg::*;

  back_state_e st_q, st_d;

  // shared restoring divider, one quotient bit per cycle on all channels
  sum_t               rem_q [CH_N];
  logic [PIX_W-1:0]   quo_q [CH_N];
  logic [CNT_W-1:0]   cnt_q;
  logic [QBIT_W-1:0]  bit_q;
  logic [OUT_W-1:0]   x_q, y_q;
  logic               done_q;

  // output register
  logic               out_valid_q;
  logic [OUT_W-1:0]   ox_q, oy_q;
  logic [PIX_W-1:0]   oval_q [CH_N];
  logic               odone_q;

  logic [SUM_W:0]     trial;
  logic               ge [CH_N];
  logic [PIX_W-1:0]   quo_nxt [CH_N];
  logic               out_free;
  logic               load_job, load_out, out_from_nxt;

  assign out_free = !out_valid_q || res_out.ready;
  assign trial    = (SUM_W+1)'(cnt_q) << bit_q;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      ge[c]      = {1'b0, rem_q[c]} >= trial;
      quo_nxt[c] = quo_q[c] | (PIX_W'(ge[c]) << bit_q);
    end
  end

  // sequencer
  always_comb begin
    st_d         = st_q;
    load_job     = 1'b0;
    load_out     = 1'b0;
    out_from_nxt = 1'b0;
    unique case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          load_job = 1'b1;
          st_d     = B_DIV;
        end
      end
      B_DIV: begin
        if (bit_q == '0) begin
          if (out_free) begin
            load_out     = 1'b1;
            out_from_nxt = 1'b1;
            st_d         = B_IDLE;
          end else begin
            st_d = B_HOLD;
          end
        end
      end
      B_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          st_d     = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  assign pop_o = load_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (load_job) begin
      for (int c = 0; c < CH_N; c++) begin
        rem_q[c] <= job_i.sums[c];
        quo_q[c] <= '0;
      end
      cnt_q  <= job_i.cnt;
      bit_q  <= QBIT_W'(PIX_W - 1);
      x_q    <= job_i.x;
      y_q    <= job_i.y;
      done_q <= job_i.done;
    end else if (st_q == B_DIV) begin
      for (int c = 0; c < CH_N; c++) begin
        if (ge[c]) begin
          rem_q[c] <= rem_q[c] - trial[SUM_W-1:0];
        end
        quo_q[c] <= quo_nxt[c];
      end
      bit_q <= bit_q - QBIT_W'(1);
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ox_q    <= x_q;
      oy_q    <= y_q;
      odone_q <= done_q;
      for (int c = 0; c < CH_N; c++) begin
        oval_q[c] <= out_from_nxt ? quo_nxt[c] : quo_q[c];
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_out.valid      = out_valid_q;
  assign res_out.out_x      = ox_q;
  assign res_out.out_y      = oy_q;
  assign res_out.out_red    = oval_q[0];
  assign res_out.out_green  = oval_q[1];
  assign res_out.out_blue   = oval_q[2];
  assign res_out.out_alpha  = oval_q[3];
  assign res_out.image_done = odone_q;

endmodule

`default_nettype wire

[rtl/box_average_image_downscale.sv]
// a pixel closing a band rectangle passes the job queue, divider and output register
// one source pixel a cycle while the job queue has room; each output pixel holds the shared
// divider for 8 quotient bits plus the load; a two-job queue lets the pixel side run ahead
// reset: asynchronous, active low; size 32 x 32, all position counters and sums cleared
// any size register write restarts the image in the same cycle
`default_nettype none

module box_average_image_downscale (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [bxavg_pkg::DIM_W-1:0] cfg_data_i,
  bxavg_pix_if.sink                        pix_in,
  bxavg_res_if.source                      res_out
);
  import bxavg_pkg::*;

  job_t push_job, pop_job;
  logic push, pop, full, empty;

  // accumulation side
  bxavg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_in),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  // queue of finished band rectangles
  bxavg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (empty)
  );

  // division side
  bxavg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (pop_job),
    .empty_i (empty),
    .pop_o   (pop),
    .res_out (res_out)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bxavg_pkg::*;

  localparam int DRAIN_CYCLES   = 24;    // pixel in flight plus divider queue
  localparam int STALL_LIMIT    = 3000;  // cycles without any beat
  localparam int RANDOM_PIXELS  = 850;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } src_pix_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             done;
  } out_pix_t;

  typedef enum logic {
    ROW_PIXEL,
    ROW_SIZE
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cfg_reg_e         sel;
    logic [DIM_W-1:0] size_val;
    src_pix_t         pix;
    bit               typed;
    out_pix_t         want;
  } step_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [DIM_W-1:0] cfg_data_i;

  bxavg_pix_if pix_if ();
  bxavg_res_if res_if ();

  box_average_image_downscale u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_if),
    .res_out    (res_if)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the downscaler: size registers, scan position, column sums
  logic [DIM_W-1:0] size_w;
  logic [DIM_W-1:0] size_h;
  logic [DIM_W-1:0] scan_col;
  logic [DIM_W-1:0] scan_row;
  logic [OUT_W:0]   band_x;
  logic [OUT_W:0]   band_y;
  logic [DIM_W-1:0] row_end;
  sum_t             acc_red   [MAX_OUT_DIM];
  sum_t             acc_green [MAX_OUT_DIM];
  sum_t             acc_blue  [MAX_OUT_DIM];
  sum_t             acc_alpha [MAX_OUT_DIM];

  out_pix_t due_pixels [$];
  int       err_count = 0;
  int       pixels_sent;
  int       avg_pixels_seen = 0;
  int       size_writes;
  bit       quiet_mode;
  out_pix_t seen_pix;
  out_pix_t want_pix;
  int       idle_cycles = 0;

  function automatic int unsigned clamp_size(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_SRC_DIM)) return MAX_SRC_DIM;
    return v;
  endfunction

  function automatic int unsigned span_of(input int unsigned s);
    return (s < MAX_OUT_DIM) ? s : MAX_OUT_DIM;
  endfunction

  // first source index of band i when s sources map onto o outputs
  function automatic int unsigned band_edge(input int unsigned i, input int unsigned s,
                                            input int unsigned o);
    return (i * s) / o;
  endfunction

  function automatic void restart_scan();
    int unsigned h;
    h = clamp_size(size_h);
    for (int i = 0; i < MAX_OUT_DIM; i++) begin
      acc_red[i]   = '0;
      acc_green[i] = '0;
      acc_blue[i]  = '0;
      acc_alpha[i] = '0;
    end
    scan_col = '0;
    scan_row = '0;
    band_x   = '0;
    band_y   = '0;
    row_end  = DIM_W'(band_edge(1, h, span_of(h)));
  endfunction

  // add one source pixel; emit is set when it closes a band rectangle
  function automatic void accumulate_pixel(input src_pix_t p, output bit emit,
                                           output out_pix_t res);
    int unsigned w, h, ow, oh, bc, col_end, cnt;
    bit          last_col, last_row;
    w        = clamp_size(size_w);
    h        = clamp_size(size_h);
    ow       = span_of(w);
    oh       = span_of(h);
    bc       = band_x % MAX_OUT_DIM;
    col_end  = band_edge(bc + 1, w, ow);
    last_col = (scan_col + 1 >= col_end);
    last_row = (scan_row + 1 >= row_end);
    emit     = 1'b0;
    res      = '0;

    acc_red[bc]   += sum_t'(p.red);
    acc_green[bc] += sum_t'(p.green);
    acc_blue[bc]  += sum_t'(p.blue);
    acc_alpha[bc] += sum_t'(p.alpha);

    // band rectangle complete: truncated average, then clear the column
    if (last_col && last_row) begin
      cnt = (col_end - band_edge(bc, w, ow)) * (row_end - band_edge(band_y, h, oh));
      if (cnt == 0) cnt = 1;
      res.x     = OUT_W'(bc);
      res.y     = OUT_W'(band_y);
      res.red   = 8'(32'(acc_red[bc]) / cnt);
      res.green = 8'(32'(acc_green[bc]) / cnt);
      res.blue  = 8'(32'(acc_blue[bc]) / cnt);
      res.alpha = 8'(32'(acc_alpha[bc]) / cnt);
      res.done  = (bc + 1 == ow) && (band_y + 1 == oh);
      acc_red[bc]   = '0;
      acc_green[bc] = '0;
      acc_blue[bc]  = '0;
      acc_alpha[bc] = '0;
      emit = 1'b1;
    end

    // advance raster position, wrap into a new image at the end
    if (last_col) band_x++;
    scan_col++;
    if (scan_col >= w) begin
      scan_col = '0;
      band_x   = '0;
      scan_row++;
      if (last_row) band_y++;
      if (scan_row >= h) begin
        scan_row = '0;
        band_y   = '0;
      end
      row_end = DIM_W'(band_edge(band_y + 1, h, oh));
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_REPORTS) begin
      $display("[%0t] mismatch on result %0d: %s got %0d want %0d", $time,
               avg_pixels_seen, what, got, want);
    end
    err_count++;
  endtask

  // mostly no gap, often short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_channel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [DIM_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return DIM_W'(1);
      1: return DIM_W'(MAX_OUT_DIM);
      2: return DIM_W'(MAX_OUT_DIM + 1);
      3: return DIM_W'(MAX_SRC_DIM);
      4: return '0;
      5: return DIM_W'($urandom_range(MAX_SRC_DIM + 1, 2047));
      6: return DIM_W'($urandom_range(MAX_OUT_DIM + 2, MAX_SRC_DIM - 1));
      default: return DIM_W'($urandom_range(1, 24));
    endcase
  endfunction

  // one source pixel beat; valid stays high into the next beat when no gap follows
  task automatic send_pixel(input src_pix_t p, input bit typed, input out_pix_t want);
    int       gap;
    bit       emit;
    out_pix_t res;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.in_red   <= p.red;
    pix_if.in_green <= p.green;
    pix_if.in_blue  <= p.blue;
    pix_if.in_alpha <= p.alpha;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    accumulate_pixel(p, emit, res);
    if (typed) due_pixels.insert(due_pixels.size(), want);
    else if (emit) due_pixels.insert(due_pixels.size(), res);
    pixels_sent++;
  endtask

  // size writes only once the block has drained
  task automatic write_size(input cfg_reg_e sel, input logic [DIM_W-1:0] val);
    pix_if.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (sel == REG_SRC_WIDTH) size_w = val;
    else size_h = val;
    restart_scan();
    size_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic step_row_t pixel_row(input src_pix_t p, input bit typed,
                                          input out_pix_t want);
    step_row_t row;
    row.kind     = ROW_PIXEL;
    row.sel      = REG_SRC_WIDTH;
    row.size_val = '0;
    row.pix      = p;
    row.typed    = typed;
    row.want     = want;
    return row;
  endfunction

  function automatic step_row_t size_row(input cfg_reg_e sel, input logic [DIM_W-1:0] val);
    step_row_t row;
    row.kind     = ROW_SIZE;
    row.sel      = sel;
    row.size_val = val;
    row.pix      = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  // check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_pix = '{res_if.out_x, res_if.out_y, res_if.out_red, res_if.out_green,
                   res_if.out_blue, res_if.out_alpha, res_if.image_done};
      if (due_pixels.size() == 0) begin
        report_mismatch("result with nothing expected, x", seen_pix.x, -1);
      end else begin
        want_pix = due_pixels.pop_front();
        if (seen_pix.x !== want_pix.x) report_mismatch("out_x", seen_pix.x, want_pix.x);
        if (seen_pix.y !== want_pix.y) report_mismatch("out_y", seen_pix.y, want_pix.y);
        if (seen_pix.red !== want_pix.red)
          report_mismatch("out_red", seen_pix.red, want_pix.red);
        if (seen_pix.green !== want_pix.green)
          report_mismatch("out_green", seen_pix.green, want_pix.green);
        if (seen_pix.blue !== want_pix.blue)
          report_mismatch("out_blue", seen_pix.blue, want_pix.blue);
        if (seen_pix.alpha !== want_pix.alpha)
          report_mismatch("out_alpha", seen_pix.alpha, want_pix.alpha);
        if (seen_pix.done !== want_pix.done)
          report_mismatch("image_done", seen_pix.done, want_pix.done);
      end
      avg_pixels_seen++;
    end
  end

  // result side back-pressure
  initial begin : result_ready
    int burst;
    int gap;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      burst = $urandom_range(1, 20);
      res_if.ready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no beat for %0d cycles, %0d results pending", $time,
               idle_cycles, due_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t        plan [$];
    src_pix_t         p;
    logic [DIM_W-1:0] w_val;
    logic [DIM_W-1:0] h_val;
    int unsigned      area;
    int               n;
    int               random_pixels;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_SRC_WIDTH;
    cfg_data_i      <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.in_red   <= '0;
    pix_if.in_green <= '0;
    pix_if.in_blue  <= '0;
    pix_if.in_alpha <= '0;
    pixels_sent     = 0;
    size_writes     = 0;
    quiet_mode      = 1'b0;
    random_pixels   = 0;
    size_w          = DIM_W'(32);
    size_h          = DIM_W'(32);
    restart_scan();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size 32 x 32: every pixel is its own band
    plan.insert(plan.size(), pixel_row('{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
                             '{5'd0, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}));
    plan.insert(plan.size(), pixel_row('{8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
                             '{5'd1, 5'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0}));
    plan.insert(plan.size(), pixel_row('{8'h55, 8'haa, 8'h0f, 8'hf0}, 1'b1,
                             '{5'd2, 5'd0, 8'h55, 8'haa, 8'h0f, 8'hf0, 1'b0}));
    // one column, 32 rows
    plan.insert(plan.size(), size_row(REG_SRC_WIDTH, DIM_W'(1)));
    plan.insert(plan.size(), pixel_row('{8'h01, 8'h02, 8'h04, 8'h08}, 1'b1,
                             '{5'd0, 5'd0, 8'h01, 8'h02, 8'h04, 8'h08, 1'b0}));
    plan.insert(plan.size(), pixel_row('{8'h80, 8'h40, 8'h20, 8'h10}, 1'b1,
                             '{5'd0, 5'd1, 8'h80, 8'h40, 8'h20, 8'h10, 1'b0}));
    // single pixel image: every pixel ends an image
    plan.insert(plan.size(), size_row(REG_SRC_HEIGHT, DIM_W'(1)));
    plan.insert(plan.size(), pixel_row('{8'h12, 8'h34, 8'h56, 8'h78}, 1'b1,
                             '{5'd0, 5'd0, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1}));
    plan.insert(plan.size(), pixel_row('{8'hff, 8'h00, 8'hff, 8'h00}, 1'b1,
                             '{5'd0, 5'd0, 8'hff, 8'h00, 8'hff, 8'h00, 1'b1}));
    // zero sizes act as one
    plan.insert(plan.size(), size_row(REG_SRC_WIDTH, '0));
    plan.insert(plan.size(), size_row(REG_SRC_HEIGHT, '0));
    plan.insert(plan.size(), pixel_row('{8'hfe, 8'h01, 8'h7f, 8'h80}, 1'b1,
                             '{5'd0, 5'd0, 8'hfe, 8'h01, 8'h7f, 8'h80, 1'b1}));
    // oversized registers clamp to 1024 x 1024
    plan.insert(plan.size(), size_row(REG_SRC_WIDTH, '1));
    plan.insert(plan.size(), size_row(REG_SRC_HEIGHT, '1));
    for (int i = 0; i < 3; i++) begin
      plan.insert(plan.size(), pixel_row('{8'hff, 8'hff, 8'hff, 8'hff}, 0, '0));
    end
    // 64 x 2: two-pixel bands, truncating average
    plan.insert(plan.size(), size_row(REG_SRC_WIDTH, DIM_W'(64)));
    plan.insert(plan.size(), size_row(REG_SRC_HEIGHT, DIM_W'(2)));
    plan.insert(plan.size(), pixel_row('{8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0));
    plan.insert(plan.size(), pixel_row('{8'h00, 8'h00, 8'h00, 8'h01}, 1'b1,
                             '{5'd0, 5'd0, 8'h7f, 8'h7f, 8'h7f, 8'h80, 1'b0}));
    // tall single column, 32-row bands
    plan.insert(plan.size(), size_row(REG_SRC_WIDTH, DIM_W'(1)));
    plan.insert(plan.size(), size_row(REG_SRC_HEIGHT, DIM_W'(MAX_SRC_DIM)));
    for (int i = 0; i < 3; i++) begin
      plan.insert(plan.size(), pixel_row('{8'h9c, 8'h63, 8'hc3, 8'h3c}, 1'b0, '0));
    end

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SIZE) write_size(plan[i].sel, plan[i].size_val);
      else send_pixel(plan[i].pix, plan[i].typed, plan[i].want);
    end

    // random phases: most often a new size, then whole images or a partial one
    while (random_pixels < RANDOM_PIXELS) begin
      if ($urandom_range(0, 4) != 0) begin
        w_val = pick_size();
        h_val = pick_size();
        if (clamp_size(w_val) * clamp_size(h_val) > 256 && $urandom_range(0, 2) != 0) begin
          h_val = DIM_W'($urandom_range(1, 4));
        end
        write_size(REG_SRC_WIDTH, w_val);
        write_size(REG_SRC_HEIGHT, h_val);
      end
      quiet_mode = ($urandom_range(0, 5) == 0);
      area = clamp_size(size_w) * clamp_size(size_h);
      if (area <= 60) n = area * $urandom_range(1, 3);
      else n = $urandom_range(40, 120);
      repeat (n) begin
        p.red   = rand_channel();
        p.green = rand_channel();
        p.blue  = rand_channel();
        p.alpha = rand_channel();
        send_pixel(p, 1'b0, '0);
        random_pixels++;
      end
    end
    quiet_mode = 1'b0;

    // drain outstanding averages
    pix_if.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d source pixels across %0d size writes, checked %0d averaged pixels",
             pixels_sent, size_writes, avg_pixels_seen);
    $display("mismatches found: %0d", err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
